### hw/rtl/sorted_descending_list_top_macros.svh
// Assertion macros for the sorted descending list.
// Taken in by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef SORTED_DESCENDING_LIST_TOP_MACROS_SVH
`define SORTED_DESCENDING_LIST_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sdl_pkg.sv
// Shared types and action codes for the sorted descending list.
// No dependencies; used by sdl_cell and sorted_descending_list_top.
`default_nettype none

package sdl_pkg;

    // Action codes carried on the input channel.
    localparam logic [2:0] ACT_INSERT     = 3'd0;
    localparam logic [2:0] ACT_REMOVE_VAL = 3'd1;
    localparam logic [2:0] ACT_READ_POS   = 3'd2;
    localparam logic [2:0] ACT_REMOVE_POS = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // Update commands broadcast to every cell; each is already qualified
    // by the transfer and by the success of the action.
    typedef struct packed {
        logic ins;      // insert the broadcast value
        logic rmv;      // remove the entry equal to the broadcast value
        logic rmp;      // remove the entry at the broadcast position
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/sorted_descending_list_top.sv
// Sorted descending list: keeps up to CAP signed Q16.16 values, largest first,
// in a row of sdl_cell slots (types and codes from sdl_pkg). Each transfer on
// the input channel carries an action (insert, remove by value, read at a
// one-based position, remove at a position, clear) and yields exactly one
// result with ok, the value read or removed at a position (zero otherwise) and
// the count after the action. Every cell compares its entry with the broadcast
// value in parallel and the whole row shifts in the same cycle as the transfer,
// so the list accepts one item per clock while the result register is free or
// being drained; each result is registered and appears in the cycle after its
// input. Entries need no clearing after reset; only fill and valid are reset.
`include "sorted_descending_list_top_macros.svh"
`default_nettype none

module sorted_descending_list_top
    import sdl_pkg::*;
#(
    parameter int CAP        = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic        [2:0]  i_action,
    input  wire logic signed [31:0] i_value,
    input  wire logic        [4:0]  i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_ok,
    output logic signed      [31:0] o_value_out,
    output logic             [4:0]  o_count
);

    localparam int FILL_W = $clog2(CAP + 1);
    localparam int CNT_W  = (FILL_W > 5) ? FILL_W : 5;
    localparam int POS_W  = CNT_W + 1;

    logic                         r_out_valid;
    logic                         r_ok;
    logic        [31:0]           r_value_out;
    logic        [4:0]            r_count;
    logic        [FILL_W-1:0]     r_fill;
    logic        [FILL_W-1:0]     n_fill;

    logic                         in_xfer;
    logic signed [VALUE_BITS-1:0] value_int;
    logic        [CAP-1:0]        gt;
    logic        [CAP-1:0]        eq;
    logic        [VALUE_BITS-1:0] data     [CAP];
    logic        [VALUE_BITS-1:0] sel_data [CAP];
    logic        [VALUE_BITS-1:0] pos_data;
    logic        [31:0]           pos_data32;
    logic                         hit;
    logic                         not_full;
    logic                         pos_ok;
    logic                         n_ok;
    logic        [31:0]           n_value_out;
    logic        [CNT_W-1:0]      fill_ext;
    t_cell_ctl                    ctl;

    // Input transfer is taken whenever the result register is free or drains.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Fit the 32-bit input value to the stored width and back.
    generate
        if (VALUE_BITS <= 32) begin : g_narrow
            assign value_int  = i_value[VALUE_BITS-1:0];
            assign pos_data32 = 32'($signed(pos_data));
        end else begin : g_wide
            assign value_int  = VALUE_BITS'(i_value);
            assign pos_data32 = pos_data[31:0];
        end
    endgenerate

    // Status gathered from the row.
    assign hit      = |eq;
    assign not_full = r_fill < FILL_W'(CAP);
    assign pos_ok   = (i_position != 5'd0) && (POS_W'(i_position) <= POS_W'(r_fill));

    always_comb begin
        pos_data = '0;
        for (int k = 0; k < CAP; k++) begin
            pos_data = pos_data | sel_data[k];
        end
    end

    // Commands to the row, qualified by the transfer and by success.
    assign ctl.ins = in_xfer && (i_action == ACT_INSERT) && not_full;
    assign ctl.rmv = in_xfer && (i_action == ACT_REMOVE_VAL) && hit;
    assign ctl.rmp = in_xfer && (i_action == ACT_REMOVE_POS) && pos_ok;

    // Result and next fill count.
    always_comb begin
        n_fill      = r_fill;
        n_ok        = 1'b0;
        n_value_out = '0;
        unique case (i_action)
            ACT_INSERT: begin
                n_ok = not_full;
                if (not_full) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            ACT_REMOVE_VAL: begin
                n_ok = hit;
                if (hit) begin
                    n_fill = r_fill - 1'b1;
                end
            end
            ACT_READ_POS: begin
                n_ok = pos_ok;
                if (pos_ok) begin
                    n_value_out = pos_data32;
                end
            end
            ACT_REMOVE_POS: begin
                n_ok = pos_ok;
                if (pos_ok) begin
                    n_value_out = pos_data32;
                    n_fill      = r_fill - 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_ok   = 1'b1;
                n_fill = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    assign fill_ext = CNT_W'(n_fill);

    // Row of cells; the first sees a virtual greater entry on its left, the last takes zero from its right.
    generate
        for (genvar g = 0; g < CAP; g++) begin : g_cell
            logic                  prev_gt;
            logic [VALUE_BITS-1:0] prev_data;
            logic [VALUE_BITS-1:0] next_data;

            if (g == 0) begin : g_first
                assign prev_gt   = 1'b1;
                assign prev_data = '0;
            end else begin : g_mid
                assign prev_gt   = gt[g-1];
                assign prev_data = data[g-1];
            end

            if (g == CAP - 1) begin : g_last
                assign next_data = '0;
            end else begin : g_inner
                assign next_data = data[g+1];
            end

            sdl_cell #(
                .VALUE_BITS (VALUE_BITS),
                .FILL_W     (FILL_W),
                .POS_W      (POS_W),
                .INDEX      (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_fill      (r_fill),
                .i_value     (value_int),
                .i_pos       (i_position),
                .i_prev_gt   (prev_gt),
                .i_prev_data (prev_data),
                .i_next_data (next_data),
                .o_gt        (gt[g]),
                .o_eq        (eq[g]),
                .o_data      (data[g]),
                .o_sel_data  (sel_data[g])
            );
        end
    endgenerate

    // Fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ok        <= n_ok;
            r_value_out <= n_value_out;
            r_count     <= fill_ext[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_value_out = r_value_out;
    assign o_count     = r_count;

    // Checks on the fill count and on the results it drives.
    `SDL_ASSERT_NOW(a_fill_in_range, 1'b1, r_fill <= FILL_W'(CAP), "fill count exceeds capacity")
    `SDL_ASSERT_NEXT(a_full_insert_fails, in_xfer && (i_action == ACT_INSERT) && !not_full, !o_ok && $stable(r_fill), "insert into a full list did not fail")
    `SDL_ASSERT_NEXT(a_clear_empties, in_xfer && (i_action == ACT_CLEAR), o_ok && (r_fill == '0) && (o_count == 5'd0), "clear did not empty the list")
    `SDL_ASSERT_NEXT(a_read_keeps_fill, in_xfer && (i_action == ACT_READ_POS), $stable(r_fill), "read changed the fill count")

endmodule

`default_nettype wire

### hw/rtl/sdl_cell.sv
// One slot of the sorted row: holds one entry and shifts with its neighbors.
// Depends on sdl_pkg for the command struct.
`default_nettype none

module sdl_cell
    import sdl_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int FILL_W     = 5,
    parameter int POS_W      = 6,
    parameter int INDEX      = 0
) (
    input  wire logic                         i_clk,
    input  wire t_cell_ctl                    i_ctl,
    input  wire logic        [FILL_W-1:0]     i_fill,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    input  wire logic        [4:0]            i_pos,
    input  wire logic                         i_prev_gt,
    input  wire logic        [VALUE_BITS-1:0] i_prev_data,
    input  wire logic        [VALUE_BITS-1:0] i_next_data,
    output logic                              o_gt,
    output logic                              o_eq,
    output logic             [VALUE_BITS-1:0] o_data,
    output logic             [VALUE_BITS-1:0] o_sel_data
);

    localparam logic [FILL_W-1:0] SLOT_IDX = FILL_W'(INDEX);
    localparam logic [POS_W-1:0]  SLOT_POS = POS_W'(INDEX + 1);

    logic [VALUE_BITS-1:0] r_data;
    logic [VALUE_BITS-1:0] n_data;
    logic                  occupied;
    logic [POS_W-1:0]      pos_ext;

    // Local compare against the broadcast value and position.
    assign occupied   = SLOT_IDX < i_fill;
    assign pos_ext    = POS_W'(i_pos);
    assign o_gt       = occupied && ($signed(r_data) > i_value);
    assign o_eq       = occupied && ($signed(r_data) == i_value);
    assign o_data     = r_data;
    assign o_sel_data = (pos_ext == SLOT_POS) ? r_data : '0;

    // Insert makes room by taking the left neighbor's entry, and the first slot not
    // greater than the value takes the value itself; removal closes the gap by
    // taking the right neighbor's entry. Without a command the entry holds.
    always_comb begin
        n_data = r_data;
        priority if (i_ctl.ins) begin
            if (!o_gt) begin
                n_data = i_prev_gt ? i_value : i_prev_data;
            end
        end else if (i_ctl.rmv) begin
            if (!o_gt) begin
                n_data = i_next_data;
            end
        end else if (i_ctl.rmp) begin
            if (pos_ext <= SLOT_POS) begin
                n_data = i_next_data;
            end
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

`default_nettype wire
